// ===== rtl/core/rcfs_pkg.sv =====
// Package for the RC failsafe joystick mapper: item codes, status codes,
// field widths and the structs passed between the mapper modules.
// No dependencies.
package rcfs_pkg;

	localparam int NUM_CHANNELS_DEF = 16;
	localparam int CHAN_W           = 11;
	localparam int IDX_IN_W         = 4;
	localparam int CNT_W            = 16;
	localparam int AXIS_W           = 16;
	localparam int NUM_AXES         = 8;
	localparam int NUM_BUTTONS      = 8;
	localparam int VIEW_CHANS       = NUM_AXES + NUM_BUTTONS;

	localparam logic [CHAN_W-1:0] MID_VALUE        = 11'd992;
	localparam logic [CNT_W-1:0]  FRAME_TIMEOUT_RST = 16'd500;
	localparam logic [CNT_W-1:0]  FREEZE_TIMEOUT_RST = 16'd1000;
	localparam logic [AXIS_W-1:0] AXIS_FAILSAFE_Z   = 16'h8001;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIMEOUT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_CHANNEL   = 2'd1,
		OP_FRAME_END = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		STATUS_BOOT      = 3'd0,
		STATUS_WAITING   = 3'd1,
		STATUS_WIRING    = 3'd2,
		STATUS_FAILSAFE  = 3'd3,
		STATUS_ACTIVE    = 3'd4
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [IDX_IN_W-1:0] channel_index;
		logic [CHAN_W-1:0]   channel_value;
		logic                frame_lost_flag;
		logic                usb_mounted;
		logic                line_busy;
		logic                sync_seen;
	} item_t;

	typedef logic [VIEW_CHANS-1:0][CHAN_W-1:0] chan_view_t;

endpackage

// ===== rtl/core/rcfs_chan_bank.sv =====
// Channel storage for the RC failsafe mapper: incoming and displayed banks
// and change detection against the displayed frame.
// Depends on rcfs_pkg.
module rcfs_chan_bank import rcfs_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  item_t      item,
	output chan_view_t view,
	output logic       frame_changed
);

	localparam int IDX_W = $clog2(NUM_CHANNELS);

	logic [CHAN_W-1:0] bank_q [2][NUM_CHANNELS];
	logic              sel_q;
	logic              sel_next;
	logic              pending_q;
	logic [IDX_W-1:0]  idx;
	logic              idx_ok;
	logic              is_chan;
	logic              is_frame;
	logic              differs;

	assign idx      = IDX_W'(item.channel_index);
	assign idx_ok   = (32'(item.channel_index) < NUM_CHANNELS);
	assign is_chan  = (item.op == OP_CHANNEL);
	assign is_frame = (item.op == OP_FRAME_END);
	assign sel_next = is_frame ? ~sel_q : sel_q;
	assign differs  = idx_ok && (bank_q[sel_q][idx] != item.channel_value);

	// Channel values go to the incoming bank; a frame end swaps the two banks.
	always_ff @(posedge clk) begin
		if (advance && is_chan && idx_ok) begin
			bank_q[~sel_q][idx] <= item.channel_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= 1'b0;
			pending_q <= 1'b0;
		end else if (advance) begin
			if (is_frame) begin
				sel_q     <= ~sel_q;
				pending_q <= 1'b0;
			end else if (is_chan && differs) begin
				pending_q <= 1'b1;
			end
		end
	end

	assign frame_changed = pending_q;

	// The view is the displayed bank as it stands after this word.
	for (genvar k = 0; k < VIEW_CHANS; k++) begin : g_view
		if (k < NUM_CHANNELS) begin : g_used
			assign view[k] = bank_q[sel_next][k];
		end else begin : g_absent
			assign view[k] = '0;
		end
	end

endmodule

// ===== rtl/core/rcfs_link_monitor.sv =====
// Link supervision for the RC failsafe mapper: timeout registers, frame and
// change age counters, baseline and active flag.
// Depends on rcfs_pkg.
module rcfs_link_monitor import rcfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  item_t                item,
	input  logic                 frame_changed,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data,
	output logic                 active_next
);

	logic [CNT_W-1:0] frame_timeout_q;
	logic [CNT_W-1:0] freeze_timeout_q;
	logic [CNT_W-1:0] ms_frame_q;
	logic [CNT_W-1:0] ms_change_q;
	logic             baseline_q;
	logic             active_q;
	logic [CNT_W-1:0] ms_frame_n;
	logic [CNT_W-1:0] ms_change_n;
	logic             baseline_n;
	logic             active_n;
	logic             fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_timeout_q  <= FRAME_TIMEOUT_RST;
			freeze_timeout_q <= FREEZE_TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_TIMEOUT:  frame_timeout_q  <= cfg_data;
				CFG_FREEZE_TIMEOUT: freeze_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ms_frame_n  = ms_frame_q;
		ms_change_n = ms_change_q;
		baseline_n  = baseline_q;
		active_n    = active_q;
		unique case (item.op)
			OP_TICK: begin
				if (ms_frame_q != '1) ms_frame_n = ms_frame_q + 1'b1;
				if (ms_change_q != '1) ms_change_n = ms_change_q + 1'b1;
			end
			OP_FRAME_END: begin
				ms_frame_n = '0;
				baseline_n = 1'b1;
				active_n   = 1'b1;
				if (!baseline_q || frame_changed) ms_change_n = '0;
			end
			default: ;
		endcase
		fail = (ms_frame_n > frame_timeout_q) ||
			(baseline_n && (ms_change_n > freeze_timeout_q)) ||
			((item.op == OP_FRAME_END) && item.frame_lost_flag);
		active_next = active_n && !fail;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_frame_q  <= '0;
			ms_change_q <= '0;
			baseline_q  <= 1'b0;
			active_q    <= 1'b0;
		end else if (advance) begin
			ms_frame_q  <= ms_frame_n;
			ms_change_q <= ms_change_n;
			baseline_q  <= baseline_n;
			active_q    <= active_next;
		end
	end

endmodule

// ===== rtl/core/rcfs_report.sv =====
// Report stage of the RC failsafe mapper: axis scaling, buttons, status
// and the output register with its handshake.
// Depends on rcfs_pkg.
module rcfs_report import rcfs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic         active,
	input  chan_view_t   view,
	input  item_t        item,
	input  logic         m_axis_tready,
	output logic         m_axis_tvalid,
	output logic [143:0] m_axis_tdata,
	output logic         room
);

	// Scales to (raw - 992) * 32767 / 819 after clamping, truncated toward zero.
	// 32767 = 40 * 819 + 7, so the quotient is 40 * |v| plus floor(7 * |v| / 819).
	function automatic logic [AXIS_W-1:0] scale_channel(input logic [CHAN_W-1:0] raw);
		logic signed [12:0] v;
		logic [9:0]         mag;
		logic [12:0]        mag7;
		logic [14:0]        q;
		logic [2:0]         corr;
		v = $signed({2'b00, raw}) - $signed({2'b00, MID_VALUE});
		if (v > 13'sd819) v = 13'sd819;
		if (v < -13'sd819) v = -13'sd819;
		mag  = v[12] ? 10'(-v) : 10'(v);
		mag7 = 13'({3'b000, mag} * 13'd7);
		corr = '0;
		for (int j = 1; j <= 7; j++) begin
			if (mag7 >= 13'(819 * j)) corr = corr + 1'b1;
		end
		q = 15'({mag, 5'b0}) + 15'({mag, 3'b0}) + 15'(corr);
		scale_channel = v[12] ? AXIS_W'(-{1'b0, q}) : AXIS_W'({1'b0, q});
	endfunction

	logic [NUM_AXES-1:0][AXIS_W-1:0] axes_d;
	logic [NUM_AXES-1:0][AXIS_W-1:0] axes_s2;
	logic [NUM_BUTTONS-1:0]          buttons_d;
	logic [NUM_BUTTONS-1:0]          buttons_s2;
	logic                            active_s2;
	status_t                         status_d;
	status_t                         status_s2;
	logic                            valid_s2;

	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			axes_d[k] = active ? scale_channel(view[k]) : '0;
		end
		if (!active) axes_d[2] = AXIS_FAILSAFE_Z;
		for (int k = 0; k < NUM_BUTTONS; k++) begin
			buttons_d[k] = active && (view[NUM_AXES + k] > MID_VALUE);
		end
		priority if (!item.usb_mounted) status_d = STATUS_BOOT;
		else if (active)                status_d = STATUS_ACTIVE;
		else if (item.sync_seen)        status_d = STATUS_FAILSAFE;
		else if (item.line_busy)        status_d = STATUS_WIRING;
		else                            status_d = STATUS_WAITING;
	end

	assign room = !valid_s2 || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (room) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && room) begin
			axes_s2    <= axes_d;
			buttons_s2 <= buttons_d;
			active_s2  <= active;
			status_s2  <= status_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'b0000, status_s2, active_s2, buttons_s2, axes_s2};

endmodule

// ===== rtl/core/rc_failsafe_axis_mapper_top.sv =====
// Top level of the RC failsafe joystick mapper: input register and the
// channel bank, link monitor and report stages.
// Depends on rcfs_pkg, rcfs_chan_bank, rcfs_link_monitor and rcfs_report.
//
// Each word on the slave stream is one event: tuser gives its kind (a one
// millisecond tick, a channel value or a frame end) and tdata carries the
// channel index, value, lost flag and three status inputs. Every accepted
// word yields exactly one joystick report word on the master stream, in order.
// The configuration channel writes the frame and freeze timeouts; it is
// always ready and should only be used while no word is in flight.
// An accepted word is held in the input register, processed by the stages
// and loaded into the output register, which drives m_axis_tvalid; a master
// stall can hold it in the input register. One word is taken every cycle
// while the output register has room or is being read; all state updates
// are a single pass of short logic between the input and output registers.
// When the master side stalls, the output word holds and one further word can
// wait in the input register before s_axis_tready falls.
// Reset clears the flags, age counters and handshake state and restores the
// timeouts to 500 and 1000 ms; channel banks hold no value until written.
module rc_failsafe_axis_mapper_top import rcfs_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [3:0] channel_index, [14:4] channel_value, [15] frame_lost_flag,
	// [16] usb_mounted, [17] line_busy, [18] sync_seen, [23:19] zero.
	input  logic [23:0]          s_axis_tdata,
	// [1:0] op.
	input  logic [1:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [15:0] axis_x, [31:16] axis_y, [47:32] axis_z, [63:48] axis_rx,
	// [79:64] axis_ry, [95:80] axis_rz, [111:96] axis_slider,
	// [127:112] axis_dial, [135:128] buttons, [136] link_active,
	// [139:137] status_mode, [143:140] zero.
	output logic [143:0]         m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	item_t      item_s1;
	logic       valid_s1;
	logic       room;
	logic       advance;
	chan_view_t view;
	logic       frame_changed;
	logic       active_next;

	assign s_axis_tready = !valid_s1 || room;
	assign advance       = valid_s1 && room;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.op              <= op_t'(s_axis_tuser);
			item_s1.channel_index   <= s_axis_tdata[3:0];
			item_s1.channel_value   <= s_axis_tdata[14:4];
			item_s1.frame_lost_flag <= s_axis_tdata[15];
			item_s1.usb_mounted     <= s_axis_tdata[16];
			item_s1.line_busy       <= s_axis_tdata[17];
			item_s1.sync_seen       <= s_axis_tdata[18];
		end
	end

	rcfs_chan_bank #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_chan_bank (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.view         (view),
		.frame_changed(frame_changed)
	);

	rcfs_link_monitor u_link_monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.frame_changed(frame_changed),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.active_next  (active_next)
	);

	rcfs_report u_report (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (valid_s1),
		.active       (active_next),
		.view         (view),
		.item         (item_s1),
		.m_axis_tready(m_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tdata (m_axis_tdata),
		.room         (room)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rc_failsafe_axis_mapper_top: a queue-fed stream driver, a monitor
// that compares every report word with a local prediction, and phased timeout settings.
// Depends on rcfs_pkg and the mapper RTL.
module tb;
	import rcfs_pkg::*;

	localparam int NCH = NUM_CHANNELS_DEF;
	localparam int HALF_SPAN = 819;
	localparam int FULL_SCALE = 32767;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_PAD = 8;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  idx;
		logic [10:0] val;
		logic        frame_lost;
		logic        usb_mounted;
		logic        line_busy;
		logic        sync_seen;
	} word_t;

	// Same layout as m_axis_tdata[139:0]: axes[0] in the lowest bits.
	typedef struct packed {
		logic [2:0]       status_mode;
		logic             link_active;
		logic [7:0]       buttons;
		logic [7:0][15:0] axes;
	} report_t;

	typedef enum int {FR_FRESH, FR_FROZEN, FR_NUDGE} frame_kind_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;
	logic [1:0]           s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [143:0]         m_axis_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CNT_W-1:0]     cfg_data = '0;

	rc_failsafe_axis_mapper_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	word_t   pending_words[$];
	report_t expected_reports[$];
	int      words_queued = 0;
	int      reports_seen = 0;
	int      error_count = 0;
	int      idle_pct = 0;
	int      drv_gap = 0;
	int      mon_gap = 0;
	int      stall_cycles = 0;
	word_t   drv_word;
	report_t got_rep, want_rep;
	int      ax;

	// Predicted mapper state.
	logic [10:0] fs_bank [2][NCH];
	logic        fs_sel = 1'b0;
	logic        fs_changed = 1'b0;
	logic        fs_baseline = 1'b0;
	logic        fs_active = 1'b0;
	logic [15:0] fs_age_frame = '0;
	logic [15:0] fs_age_change = '0;
	logic [15:0] fs_frame_to = FRAME_TIMEOUT_RST;
	logic [15:0] fs_freeze_to = FREEZE_TIMEOUT_RST;

	// Stimulus-side copy of the banks, used to build frozen and nudged frames.
	logic [10:0] gen_bank [2][NCH];
	logic [15:0] gen_written [2] = '{16'h0000, 16'h0000};
	logic        gen_sel = 1'b0;

	int directed_values [16] = '{0, 2047, 172, 173, 1811, 1812, 992, 991,
		993, 992, 0, 2047, 1000, 500, 1500, 1};
	int edge_values [15] = '{0, 1, 171, 172, 173, 174, 991, 992, 993,
		1810, 1811, 1812, 1813, 2046, 2047};

	initial begin
		for (int b = 0; b < 2; b++)
			for (int c = 0; c < NCH; c++) begin
				fs_bank[b][c] = '0;
				gen_bank[b][c] = '0;
			end
	end

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic report_t predict_report(input word_t w);
		report_t r;
		int v;
		int k;
		unique case (w.op)
		OP_TICK: begin
			if (fs_age_frame != 16'hFFFF) fs_age_frame++;
			if (fs_age_change != 16'hFFFF) fs_age_change++;
		end
		OP_CHANNEL: begin
			if (fs_bank[fs_sel][w.idx] != w.val) fs_changed = 1'b1;
			fs_bank[!fs_sel][w.idx] = w.val;
		end
		OP_FRAME_END: begin
			fs_sel = !fs_sel;
			if (!fs_baseline || fs_changed) fs_age_change = '0;
			fs_baseline = 1'b1;
			fs_changed = 1'b0;
			fs_age_frame = '0;
			fs_active = 1'b1;
		end
		default: ;
		endcase
		if (fs_active && (fs_age_frame > fs_frame_to ||
				(fs_baseline && fs_age_change > fs_freeze_to) ||
				(w.op == OP_FRAME_END && w.frame_lost)))
			fs_active = 1'b0;
		r = '0;
		if (fs_active) begin
			for (k = 0; k < NUM_AXES; k++) begin
				v = int'(fs_bank[fs_sel][k]) - int'(MID_VALUE);
				if (v > HALF_SPAN) v = HALF_SPAN;
				if (v < -HALF_SPAN) v = -HALF_SPAN;
				v = v * FULL_SCALE / HALF_SPAN;
				r.axes[k] = v[15:0];
			end
			for (k = 0; k < NUM_BUTTONS; k++)
				r.buttons[k] = fs_bank[fs_sel][NUM_AXES + k] > MID_VALUE;
		end else begin
			r.axes[2] = AXIS_FAILSAFE_Z;
		end
		r.link_active = fs_active;
		if (!w.usb_mounted) r.status_mode = STATUS_BOOT;
		else if (fs_active) r.status_mode = STATUS_ACTIVE;
		else if (w.sync_seen) r.status_mode = STATUS_FAILSAFE;
		else if (w.line_busy) r.status_mode = STATUS_WIRING;
		else r.status_mode = STATUS_WAITING;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic logic [2:0] rand_status();
		logic mounted, line_b, sync_b;
		mounted = $urandom_range(0, 7) != 0;
		line_b = 1'($urandom_range(0, 1));
		sync_b = 1'($urandom_range(0, 1));
		return {sync_b, line_b, mounted};
	endfunction

	function automatic logic [10:0] pick_value();
		if ($urandom_range(0, 99) < 40) return 11'(edge_values[$urandom_range(0, 14)]);
		return 11'($urandom_range(0, 2047));
	endfunction

	task automatic queue_word(input logic [1:0] op, input logic [3:0] idx,
			input logic [10:0] val, input logic lost, input logic [2:0] status);
		word_t w;
		w.op = op;
		w.idx = idx;
		w.val = val;
		w.frame_lost = lost;
		{w.sync_seen, w.line_busy, w.usb_mounted} = status;
		if (op == OP_CHANNEL) begin
			gen_bank[!gen_sel][idx] = val;
			gen_written[!gen_sel][idx] = 1'b1;
		end else if (op == OP_FRAME_END) begin
			gen_sel = !gen_sel;
		end
		pending_words.push_back(w);
		words_queued++;
	endtask

	task automatic queue_tick();
		queue_word(OP_TICK, 4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)),
			1'($urandom_range(0, 1)), rand_status());
	endtask

	task automatic queue_frame(input frame_kind_t kind, input int tick_pct,
			input bit partial, input bit lost);
		int order [16];
		int count, nudge_ch, dup_ch, i, j, t, k;
		logic [10:0] v;
		for (k = 0; k < 16; k++) order[k] = k;
		if ($urandom_range(0, 1)) begin
			for (k = 15; k > 0; k--) begin
				j = $urandom_range(0, k);
				t = order[k];
				order[k] = order[j];
				order[j] = t;
			end
		end
		count = partial ? $urandom_range(0, 15) : 16;
		nudge_ch = $urandom_range(0, 15);
		dup_ch = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : -1;
		for (i = 0; i < count; i++) begin
			k = order[i];
			unique case (kind)
			FR_FRESH: v = pick_value();
			FR_FROZEN: v = gen_bank[gen_sel][k];
			default: v = (k == nudge_ch) ?
				gen_bank[gen_sel][k] ^ (11'd1 << $urandom_range(0, 10)) :
				gen_bank[gen_sel][k];
			endcase
			if ($urandom_range(0, 99) < tick_pct) queue_tick();
			// A differing write followed by the final value still counts as a change.
			if (k == dup_ch)
				queue_word(OP_CHANNEL, 4'(k), pick_value(), 1'($urandom_range(0, 1)),
					rand_status());
			queue_word(OP_CHANNEL, 4'(k), v, 1'($urandom_range(0, 1)), rand_status());
		end
		queue_word(OP_FRAME_END, 4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)),
			lost, rand_status());
	endtask

	task automatic queue_mix(input int n, input int tick_run_max);
		int start, pick;
		logic [1:0] op;
		bit full_in;
		start = words_queued;
		while (words_queued - start < n) begin
			full_in = gen_written[!gen_sel] == 16'hFFFF;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_frame(frame_kind_t'($urandom_range(0, 2)), $urandom_range(0, 20),
					1'b0, $urandom_range(0, 9) == 0);
			end else if (pick < 65 && full_in) begin
				queue_frame(frame_kind_t'($urandom_range(0, 2)), $urandom_range(0, 20),
					1'b1, $urandom_range(0, 9) == 0);
			end else if (pick < 88) begin
				repeat ($urandom_range(1, tick_run_max)) queue_tick();
			end else begin
				op = 2'($urandom_range(0, 3));
				if (op == OP_FRAME_END && !full_in) op = OP_CHANNEL;
				queue_word(op, 4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)),
					1'($urandom_range(0, 1)), rand_status());
			end
		end
	endtask

	task automatic wait_drained();
		while (reports_seen < words_queued) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		unique case (idx)
		CFG_FRAME_TIMEOUT: fs_frame_to = val;
		CFG_FREEZE_TIMEOUT: fs_freeze_to = val;
		default: ;
		endcase
	endtask

	task automatic run_phase(input int frame_to, input int freeze_to, input int n,
			input int tick_run_max, input int idle);
		write_reg(CFG_FRAME_TIMEOUT, 16'(frame_to));
		write_reg(CFG_FREEZE_TIMEOUT, 16'(freeze_to));
		idle_pct = idle;
		queue_mix(n, tick_run_max);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_reports.push_back(predict_report(drv_word));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (drv_gap > 0) begin
					drv_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_words.size() > 0 &&
						!(idle_pct > 0 && $urandom_range(0, 99) < idle_pct)) begin
					drv_word = pending_words.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {5'b0, drv_word.sync_seen, drv_word.line_busy,
						drv_word.usb_mounted, drv_word.frame_lost, drv_word.val, drv_word.idx};
					s_axis_tuser <= drv_word.op;
				end else begin
					if (pending_words.size() > 0) drv_gap = $urandom_range(0, 8);
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				reports_seen++;
				got_rep = m_axis_tdata[139:0];
				if (expected_reports.size() == 0) begin
					flag_error("report word with no item pending");
				end else begin
					want_rep = expected_reports.pop_front();
					for (ax = 0; ax < NUM_AXES; ax++)
						if (got_rep.axes[ax] !== want_rep.axes[ax])
							flag_error($sformatf("word %0d axis %0d: got %0d, expected %0d",
								reports_seen, ax, $signed(got_rep.axes[ax]),
								$signed(want_rep.axes[ax])));
					if (got_rep.buttons !== want_rep.buttons)
						flag_error($sformatf("word %0d buttons: got %h, expected %h",
							reports_seen, got_rep.buttons, want_rep.buttons));
					if (got_rep.link_active !== want_rep.link_active)
						flag_error($sformatf("word %0d link_active: got %b, expected %b",
							reports_seen, got_rep.link_active, want_rep.link_active));
					if (got_rep.status_mode !== want_rep.status_mode)
						flag_error($sformatf("word %0d status_mode: got %0d, expected %0d",
							reports_seen, got_rep.status_mode, want_rep.status_mode));
				end
			end
			if (mon_gap > 0) begin
				mon_gap--;
				m_axis_tready <= 1'b0;
			end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				mon_gap = $urandom_range(0, 8);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Default timeouts: status codes before any frame, one frame of edge values, then a random mix.
		idle_pct = 15;
		queue_word(OP_UNUSED, 4'd0, 11'd0, 1'b0, 3'b000);
		queue_word(OP_TICK, 4'd15, 11'd2047, 1'b1, 3'b001);
		queue_word(OP_TICK, 4'd0, 11'd0, 1'b0, 3'b011);
		queue_word(OP_UNUSED, 4'd15, 11'd2047, 1'b1, 3'b111);
		for (k = 0; k < 16; k++)
			queue_word(OP_CHANNEL, 4'(k), 11'(directed_values[k]), 1'(k % 2), rand_status());
		queue_word(OP_FRAME_END, 4'd0, 11'd0, 1'b0, 3'b001);
		queue_word(OP_UNUSED, 4'd7, 11'd1024, 1'b1, 3'b111);
		queue_word(OP_TICK, 4'd0, 11'd0, 1'b0, 3'b101);
		queue_mix(150, 40);
		wait_drained();

		run_phase(0, 0, 60, 3, 15);
		run_phase(1, 1, 80, 4, 30);
		run_phase(60000, 5, 100, 12, 30);
		run_phase(3, 60000, 100, 8, 0);
		repeat (6)
			run_phase($urandom_range(1, 40), $urandom_range(1, 120), 110, 30,
				$urandom_range(0, 2) * 15);
		run_phase($urandom_range(1, 40), $urandom_range(1, 120), 120, 30, 0);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
